/* rtl/b64lw_pkg.sv */
// Shared types, constants and the alphabet lookup for the line-wrapped base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

package b64lw_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned LIMIT_W     = 10;
    localparam int unsigned LINE_W      = 11;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd200;
    localparam logic               REG_LINE_LIMIT = 1'b0;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_NL  = 8'h0A;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        last;
        logic        nl;
    } t_group;

    function automatic logic [7:0] sym(input logic [5:0] six);
        logic [7:0] wide;
        wide = {2'b00, six};
        if (six < 6'd26) begin
            return 8'h41 + wide;
        end else if (six < 6'd52) begin
            return 8'h47 + wide;
        end else if (six < 6'd62) begin
            return wide - 8'd4;
        end else if (six == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

/* rtl/b64lw_front.sv */
// Front end: gathers bytes into groups of up to three and tracks the line count.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [b64lw_pkg::LIMIT_W-1:0]   i_line_limit,
    input  logic                            i_accept,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    output logic                            o_push,
    output b64lw_pkg::t_group               o_group
);
    import b64lw_pkg::*;

    logic [15:0]       r_held;
    logic [15:0]       n_held;
    logic [1:0]        r_fill;
    logic [1:0]        n_fill;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] n_line;
    logic [LINE_W-1:0] line_sum;
    logic              close;
    logic              wrap;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;

    assign close    = i_accept && (i_last || r_fill == 2'd2);
    assign line_sum = r_line + LINE_W'(4);
    assign wrap     = line_sum > {1'b0, i_line_limit};

    always_comb begin
        b0 = (r_fill == 2'd0) ? i_byte : r_held[15:8];
        b1 = (r_fill == 2'd0) ? 8'h00 : ((r_fill == 2'd1) ? i_byte : r_held[7:0]);
        b2 = (r_fill == 2'd2) ? i_byte : 8'h00;

        o_push         = close;
        o_group.bits   = {b0, b1, b2};
        o_group.nbytes = r_fill + 2'd1;
        o_group.last   = i_last;
        o_group.nl     = wrap;

        n_held = r_held;
        n_fill = r_fill;
        n_line = r_line;
        if (close) begin
            n_held = 16'h0000;
            n_fill = 2'd0;
            n_line = (wrap || i_last) ? '0 : line_sum;
        end else if (i_accept) begin
            n_fill = r_fill + 2'd1;
            if (r_fill == 2'd0) begin
                n_held = {i_byte, 8'h00};
            end else begin
                n_held = {r_held[15:8], i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'h0000;
            r_fill <= 2'd0;
            r_line <= '0;
        end else begin
            r_held <= n_held;
            r_fill <= n_fill;
            r_line <= n_line;
        end
    end

endmodule

/* rtl/b64lw_fifo.sv */
// Short queue of closed groups between the front and back ends.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_fifo #(
    parameter int unsigned DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64lw_pkg::t_group i_data,
    input  logic              i_pop,
    output b64lw_pkg::t_group o_data,
    output logic              o_full,
    output logic              o_empty
);
    import b64lw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_group           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("group queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("group queue count out of range");

endmodule

/* rtl/b64lw_back.sv */
// Back end: group to four symbols and an optional newline, one per cycle unless stalled.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  b64lw_pkg::t_group i_q_data,
    output logic              o_q_pop,
    output logic [7:0]        o_char,
    output logic              o_last,
    output logic              o_empty,
    input  logic              i_pop
);
    import b64lw_pkg::*;

    localparam logic [2:0] IDX_C0 = 3'd0;
    localparam logic [2:0] IDX_C1 = 3'd1;
    localparam logic [2:0] IDX_C2 = 3'd2;
    localparam logic [2:0] IDX_C3 = 3'd3;
    localparam logic [2:0] IDX_NL = 3'd4;

    t_group     r_wrec;
    t_group     n_wrec;
    logic       r_wvalid;
    logic       n_wvalid;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_char;
    logic [7:0] n_char;
    logic       r_last;
    logic       n_last;
    logic       adv;
    logic       emit;
    logic       fin;
    logic       load;
    logic [7:0] cur_char;

    assign adv  = !r_out_valid || i_pop;
    assign emit = r_wvalid && adv;
    assign fin  = (r_idx == IDX_C3 && !r_wrec.nl) || r_idx == IDX_NL;
    assign load = !i_q_empty && (!r_wvalid || (emit && fin));

    assign o_q_pop = load;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_empty = !r_out_valid;

    always_comb begin
        case (r_idx)
            IDX_C0:  cur_char = sym(r_wrec.bits[23:18]);
            IDX_C1:  cur_char = sym(r_wrec.bits[17:12]);
            IDX_C2:  cur_char = (r_wrec.nbytes >= 2'd2) ? sym(r_wrec.bits[11:6]) : CHAR_PAD;
            IDX_C3:  cur_char = (r_wrec.nbytes == 2'd3) ? sym(r_wrec.bits[5:0]) : CHAR_PAD;
            default: cur_char = CHAR_NL;
        endcase
    end

    always_comb begin
        n_wrec      = r_wrec;
        n_wvalid    = r_wvalid;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = cur_char;
            n_last      = r_wrec.last && fin;
            n_idx       = r_idx + 3'd1;
            if (fin) begin
                n_wvalid = 1'b0;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_wrec   = i_q_data;
            n_wvalid = 1'b1;
            n_idx    = IDX_C0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrec <= n_wrec;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid    <= 1'b0;
            r_idx       <= IDX_C0;
            r_out_valid <= 1'b0;
        end else begin
            r_wvalid    <= n_wvalid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    a_nl_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wvalid && r_idx == IDX_NL |-> r_wrec.nl)
        else $error("newline slot reached on a group without newline");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wvalid |-> r_idx <= IDX_NL)
        else $error("symbol index out of range");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_char) && $stable(r_last))
        else $error("waiting result dropped or changed");

endmodule

/* rtl/base64_line_wrapped_encoder.sv */
// Top level of the line-wrapped base64 encoder: APB register, front end, group queue, back end.
// Depends on b64lw_pkg, b64lw_front, b64lw_fifo, b64lw_back.
//
//   Channel   Handshake              Payload
//   input     push / full            i_in_byte, i_in_last
//   result    empty / pop            o_out_char, o_out_last
//   config    psel/penable/pwrite    paddr, pwdata, prdata (line_limit at 0x0)
//
// A byte is taken while push is high and the group queue has room; closing a group pushes it.
// The first character of a group passes through the queue, the back end's group register and its output register.
// The back end sends one character per cycle while the output is popped: 4 or 5 per group.
// A result waits in an output register; a stalled pop fills the queue, then raises full.
// Synchronous active-low reset clears the held bytes, line count, queue and output.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_in_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_char,
    output logic                           o_out_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [b64lw_pkg::PADDR_W-1:0]  paddr,
    input  logic [b64lw_pkg::PDATA_W-1:0]  pwdata,
    output logic [b64lw_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import b64lw_pkg::*;

    logic [LIMIT_W-1:0] r_line_limit;
    logic               reg_wr;
    logic               accept;
    logic               grp_push;
    t_group             grp_in;
    t_group             grp_out;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready && paddr[2] == REG_LINE_LIMIT;
    assign prdata = (paddr[2] == REG_LINE_LIMIT) ?
                    {{(PDATA_W - LIMIT_W){1'b0}}, r_line_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LIMIT_RESET;
        end else if (reg_wr) begin
            r_line_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    b64lw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_limit (r_line_limit),
        .i_accept     (accept),
        .i_byte       (i_in_byte),
        .i_last       (i_in_last),
        .o_push       (grp_push),
        .o_group      (grp_in)
    );

    b64lw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grp_push),
        .i_data  (grp_in),
        .i_pop   (q_pop),
        .o_data  (grp_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    b64lw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (grp_out),
        .o_q_pop   (q_pop),
        .o_char    (o_out_char),
        .o_last    (o_out_last),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

/* dv/base64_line_wrapped_encoder_tb.sv */
// Self-checking testbench for base64_line_wrapped_encoder: a directed table, then random
// messages, checked character by character against an in-bench encoder with line wrapping.
// Depends on b64lw_pkg and the base64_line_wrapped_encoder RTL.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_tb;

    import b64lw_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_LINE_LIMIT = PADDR_W'(4 * REG_LINE_LIMIT);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = PADDR_W'(4);
    localparam int                 SETTLE_CYCLES   = 8;
    localparam int                 ITEMS_PER_PHASE = 85;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_REG_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [7:0]           data;
        logic                 last;
        logic [PADDR_W-1:0]   addr;
        logic [LIMIT_W-1:0]   value;
        logic                 typed;
        logic [2:0]           n_typed;
        logic [39:0]          typed_chars;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_in_byte;
    logic               i_in_last;
    logic               empty;
    logic               pop;
    logic [7:0]         o_out_char;
    logic               o_out_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [15:0]        held_pair;
    logic [1:0]         bytes_held;
    logic [LINE_W-1:0]  line_count;
    logic [LIMIT_W-1:0] line_limit_shadow;

    t_enc_char          expected_chars[$];
    t_stim_row          directed_rows[$];
    int                 error_count;
    int                 sender_idle_pct;
    int                 rx_stall_pct;

    base64_line_wrapped_encoder i_dut (.*);

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 50) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return "A" + v;
        end else if (v < 6'd52) begin
            return "a" + (v - 6'd26);
        end else if (v < 6'd62) begin
            return "0" + (v - 6'd52);
        end else if (v == 6'd62) begin
            return "+";
        end
        return "/";
    endfunction

    // Characters are packed oldest first, the newest in the low byte.
    task automatic encode_byte(input logic [7:0] b, input logic lst,
                               output int n, output logic [39:0] chars);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        n = 0;
        chars = '0;
        if (!lst && bytes_held < 2'd2) begin
            if (bytes_held == 2'd0) begin
                held_pair = {b, 8'h00};
            end else begin
                held_pair[7:0] = b;
            end
            bytes_held++;
        end else begin
            b0 = (bytes_held == 2'd0) ? b : held_pair[15:8];
            b1 = (bytes_held == 2'd0) ? 8'h00 : ((bytes_held == 2'd1) ? b : held_pair[7:0]);
            b2 = (bytes_held == 2'd2) ? b : 8'h00;
            chars = {8'h00,
                     b64_char(b0[7:2]),
                     b64_char({b0[1:0], b1[7:4]}),
                     (bytes_held >= 2'd1) ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD,
                     (bytes_held == 2'd2) ? b64_char(b2[5:0]) : CHAR_PAD};
            n = 4;
            line_count = line_count + LINE_W'(4);
            if (line_count > {1'b0, line_limit_shadow}) begin
                chars = {chars[31:0], CHAR_NL};
                n = 5;
                line_count = '0;
            end
            held_pair = '0;
            bytes_held = '0;
            if (lst) begin
                line_count = '0;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input logic [2:0] n_typed, input logic [39:0] typed_chars);
        int         n;
        logic [39:0] chars;
        t_enc_char  e;
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= lst;
        do @(posedge i_clk); while (full);
        encode_byte(b, lst, n, chars);
        if (typed) begin
            n = int'(n_typed);
            chars = typed_chars;
        end
        for (int k = 0; k < n; k++) begin
            e.ch   = chars[8*(n-1-k) +: 8];
            e.last = lst && (k == n - 1);
            expected_chars.insert(expected_chars.size(), e);
        end
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drain first, then write the given address and read back the limit register.
    task automatic configure(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] wdata);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_LINE_LIMIT) begin
            line_limit_shadow = wdata[LIMIT_W-1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LINE_LIMIT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[LIMIT_W-1:0] !== line_limit_shadow) begin
            report_mismatch($sformatf("line_limit read %0d expected %0d",
                                      prdata[LIMIT_W-1:0], line_limit_shadow));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_stim_row byte_row(input logic [7:0] b, input logic lst);
        t_stim_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.data = b;
        r.last = lst;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] b, input logic lst,
                                            input logic [2:0] n, input logic [39:0] chars);
        t_stim_row r;
        r = byte_row(b, lst);
        r.typed = 1'b1;
        r.n_typed = n;
        r.typed_chars = chars;
        return r;
    endfunction

    function automatic t_stim_row write_row(input logic [PADDR_W-1:0] addr,
                                            input logic [LIMIT_W-1:0] value);
        t_stim_row r;
        r = '0;
        r.kind = ROW_REG_WRITE;
        r.addr = addr;
        r.value = value;
        return r;
    endfunction

    function automatic void add_row(input t_stim_row r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    always @(posedge i_clk) begin
        t_enc_char head;
        pop <= ($urandom_range(99) >= rx_stall_pct);
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b", o_out_char, o_out_last));
            end else begin
                head = expected_chars.pop_front();
                if (o_out_char !== head.ch) begin
                    report_mismatch($sformatf("out_char %h expected %h", o_out_char, head.ch));
                end
                if (o_out_last !== head.last) begin
                    report_mismatch($sformatf("out_last %b expected %b on char %h",
                                              o_out_last, head.last, head.ch));
                end
            end
        end
    end

    initial begin
        t_stim_row r;
        int        len;
        int        phase_items;
        error_count       = 0;
        sender_idle_pct   = 0;
        rx_stall_pct      = 0;
        held_pair         = '0;
        bytes_held        = '0;
        line_count        = '0;
        line_limit_shadow = LIMIT_RESET;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_in_byte <= '0;
        i_in_last <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte, two-byte and three-byte groups at the reset limit
        add_row(typed_row(8'h00, 1'b1, 3'd4, 40'("AA==")));
        add_row(typed_row(8'hFF, 1'b1, 3'd4, 40'("/w==")));
        add_row(typed_row(8'h4D, 1'b0, 3'd0, 40'h0));
        add_row(typed_row(8'h61, 1'b0, 3'd0, 40'h0));
        add_row(typed_row(8'h6E, 1'b1, 3'd4, 40'("TWFu")));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(byte_row(8'hFF, 1'b0));
        add_row(typed_row(8'hFF, 1'b0, 3'd4, 40'("////")));
        add_row(byte_row(8'h00, 1'b0));
        add_row(byte_row(8'h80, 1'b1));
        // zero limit: newline after every group, last flag moves to the newline
        add_row(write_row(ADDR_LINE_LIMIT, 10'd0));
        add_row(typed_row(8'h00, 1'b1, 3'd5, 40'("AA==\n")));
        add_row(byte_row(8'h12, 1'b0));
        add_row(byte_row(8'h34, 1'b0));
        add_row(byte_row(8'h56, 1'b1));
        add_row(write_row(ADDR_LINE_LIMIT, 10'd4));
        add_row(byte_row(8'h10, 1'b0));
        add_row(byte_row(8'h20, 1'b0));
        add_row(byte_row(8'h30, 1'b0));
        add_row(byte_row(8'h40, 1'b0));
        add_row(byte_row(8'h50, 1'b1));
        // limit change with a byte held
        add_row(write_row(ADDR_LINE_LIMIT, 10'd1023));
        add_row(byte_row(8'h01, 1'b0));
        add_row(write_row(ADDR_LINE_LIMIT, 10'd0));
        add_row(byte_row(8'h02, 1'b1));
        // unmapped address leaves the limit alone
        add_row(write_row(ADDR_UNMAPPED, 10'd1023));
        add_row(byte_row(8'hAA, 1'b1));
        add_row(write_row(ADDR_LINE_LIMIT, 10'd1023));
        add_row(byte_row(8'hC3, 1'b1));

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_REG_WRITE) begin
                configure(r.addr,
                          ({$urandom} & ~{{(PDATA_W-LIMIT_W){1'b0}}, {LIMIT_W{1'b1}}})
                          | {{(PDATA_W-LIMIT_W){1'b0}}, r.value});
            end else begin
                send_byte(r.data, r.last, r.typed, r.n_typed, r.typed_chars);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    rx_stall_pct    = 0;
                    configure(ADDR_LINE_LIMIT, {$urandom} & ~32'h3FF | $urandom_range(12));
                end
                1: begin
                    sender_idle_pct = 82;
                    rx_stall_pct    = 0;
                    configure(ADDR_LINE_LIMIT, {$urandom} & ~32'h3FF | $urandom_range(60, 13));
                end
                2: begin
                    sender_idle_pct = 0;
                    rx_stall_pct    = 82;
                    configure(ADDR_LINE_LIMIT, {$urandom} & ~32'h3FF | $urandom_range(6));
                end
                default: begin
                    sender_idle_pct = 12;
                    rx_stall_pct    = 12;
                    configure(ADDR_LINE_LIMIT, {$urandom} & ~32'h3FF | 32'd1023);
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(9, 1);
                for (int k = 0; k < len; k++) begin
                    send_byte(8'($urandom_range(255)), k == len - 1, 1'b0, 3'd0, 40'h0);
                    sender_gap();
                end
                phase_items += len;
                // at random, hold off until the encoder has flushed everything
                if ($urandom_range(29) == 0) begin
                    drain_results();
                end
            end
        end

        push <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
